FILE: rtl/uart_led_command_pwm_controller_unit_macros.svh
// assertion macros for the controller rtl, used by the output buffer
// assumes clk and rst are in scope where a macro is used
`ifndef UART_LED_COMMAND_PWM_CONTROLLER_UNIT_MACROS_SVH
`define UART_LED_COMMAND_PWM_CONTROLLER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define ULCP_ASSERT_IMPLY(name, cond, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("ulcp assertion failed");
`define ULCP_ASSERT_NEXT(name, cond, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("ulcp assertion failed");
`else
`define ULCP_ASSERT_IMPLY(name, cond, prop)
`define ULCP_ASSERT_NEXT(name, cond, prop)
`endif

`endif

FILE: rtl/ulcp_pkg.sv
// types, constants and helpers for the led command / pwm controller
// no dependencies
package ulcp_pkg;

  localparam int LED_COUNT = 12;
  localparam int LED_W     = 12;
  localparam logic [LED_W-1:0] LED_MASK = LED_W'((1 << LED_COUNT) - 1);

  localparam logic [6:0] PERIOD    = 7'd100;
  localparam logic [6:0] DUTY_STEP = 7'd10;
  localparam int         POT_DIV   = 455;

  localparam logic [7:0] CH_COMMA = ",";
  localparam logic [7:0] CH_SEMI  = ";";
  localparam logic [7:0] CH_EQ    = "=";
  localparam logic [7:0] CH_ZERO  = "0";
  localparam logic [7:0] CH_ONE   = "1";
  localparam logic [7:0] CH_NINE  = "9";
  localparam logic [7:0] CH_L     = "L";
  localparam logic [7:0] CH_E     = "E";
  localparam logic [7:0] CH_D     = "D";
  localparam logic [7:0] CH_P     = "P";
  localparam logic [7:0] CH_W     = "W";
  localparam logic [7:0] CH_M     = "M";

  typedef enum logic [1:0] {
    FUNC_CHAR     = 2'd0,
    FUNC_BRIGHTEN = 2'd1,
    FUNC_DIM      = 2'd2,
    FUNC_TICK     = 2'd3
  } func_t;

  typedef struct packed {
    logic       led_hit;
    logic [3:0] led_idx;
    logic       led_set;
    logic       pwm_hit;
    logic [6:0] pwm_duty;
  } match_t;

  typedef struct packed {
    logic             echo_valid;
    logic [7:0]       echo_char;
    logic [LED_W-1:0] led_enables;
    logic [6:0]       duty_level;
    logic [6:0]       brightness;
    logic [LED_W-1:0] led_on;
  } out_item_t;

  // pot / 455 for a 12-bit sample: count the thresholds passed
  function automatic logic [3:0] pot_div(input logic [11:0] pot);
    logic [3:0] q;
    q = 4'd0;
    for (int k = 1; k <= 9; k++) begin
      if (pot >= 12'(k * POT_DIV)) q = q + 4'd1;
    end
    return q;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

FILE: rtl/ulcp_match.sv
// command matcher: decodes the 8-character window into pending updates
// depends on ulcp_pkg
module ulcp_match
  import ulcp_pkg::*;
(
  input  logic [63:0] window,
  output match_t      hit
);

  logic [7:0] b [8];
  logic [6:0] nn;
  logic [6:0] val;
  logic       num_ok;

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      b[k] = window[8*(7-k) +: 8];
    end
  end

  // digits are ascii 0x30..0x39, so the low nibble is the value
  assign num_ok = is_digit(b[3]) && is_digit(b[4]) && (b[5] == CH_EQ);
  assign nn     = 7'(b[3][3:0]) * 7'd10 + 7'(b[4][3:0]);
  assign val    = 7'(b[6][3:0]) * 7'd10 + 7'(b[7][3:0]);

  always_comb begin
    hit = '0;
    if (num_ok && b[0] == CH_L && b[1] == CH_E && b[2] == CH_D) begin
      if (b[6] == CH_ZERO && nn >= 7'd4 && nn < 7'(4 + LED_COUNT)
          && (b[7] == CH_ONE || b[7] == CH_ZERO)) begin
        hit.led_hit = 1'b1;
        hit.led_idx = 4'(nn - 7'd4);
        hit.led_set = (b[7] == CH_ONE);
      end
    end else if (num_ok && b[0] == CH_P && b[1] == CH_W && b[2] == CH_M
                 && nn == 7'd1 && is_digit(b[6]) && is_digit(b[7])
                 && val <= 7'd10) begin
      hit.pwm_hit  = 1'b1;
      hit.pwm_duty = (val << 3) + (val << 1);
    end
  end

endmodule

FILE: rtl/ulcp_out_buf.sv
// two-word output buffer so a new word is taken while one waits
// depends on ulcp_pkg and the assertion macro header
`include "uart_led_command_pwm_controller_unit_macros.svh"
module ulcp_out_buf
  import ulcp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  out_item_t push_data,
  output logic      full,
  output logic      pop_valid,
  input  logic      pop_ready,
  output out_item_t pop_data
);

  out_item_t  slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign full      = (count == 2'd2);
  assign pop_valid = (count != 2'd0);
  assign pop       = pop_valid && pop_ready;
  assign pop_data  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  `ULCP_ASSERT_IMPLY(a_count_max, 1'b1, count <= 2'd2)
  `ULCP_ASSERT_IMPLY(a_no_push_full, push, !full)
  `ULCP_ASSERT_NEXT(a_count_up, push && !pop, count == $past(count) + 2'd1)
  `ULCP_ASSERT_NEXT(a_count_down, pop && !push, count == $past(count) - 2'd1)

endmodule

FILE: rtl/uart_led_command_pwm_controller_unit.sv
// led command / pwm controller: one word in, one result word out
// each accepted word writes its result into the output buffer; one word per cycle while in_ready is high
// state update and result are one combinational pass into a 2-word output buffer
// in_ready drops only when both buffer words wait; rst clears window, enables
// to all on, duty, pwm slot and brightness to zero; depends on ulcp_pkg
module uart_led_command_pwm_controller_unit
  import ulcp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       func,
  input  logic [7:0]       rx_char,
  input  logic [11:0]      pot_sample,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             echo_valid,
  output logic [7:0]       echo_char,
  output logic [LED_W-1:0] led_enables,
  output logic [6:0]       duty_level,
  output logic [6:0]       brightness,
  output logic [LED_W-1:0] led_on
);

  logic [63:0]      char_window, char_window_next;
  logic [LED_W-1:0] enables_committed, enables_committed_next;
  logic [LED_W-1:0] enables_pending, enables_pending_next;
  logic [6:0]       duty_committed, duty_committed_next;
  logic [6:0]       duty_pending, duty_pending_next;
  logic [6:0]       pwm_phase, pwm_phase_next;
  logic [6:0]       pwm_brightness, pwm_brightness_next;

  func_t      fn;
  logic       in_fire;
  logic       buf_full;
  match_t     hit;
  logic       delim;
  logic [6:0] slot_shown;
  logic [6:0] bright_sum;
  out_item_t  item;
  out_item_t  pop_item;

  assign fn       = func_t'(func);
  assign in_ready = !buf_full;
  assign in_fire  = in_valid && in_ready;
  assign delim    = (rx_char == CH_COMMA) || (rx_char == CH_SEMI);

  ulcp_match u_match (
    .window (char_window),
    .hit    (hit)
  );

  assign bright_sum = duty_committed + 7'(pot_div(pot_sample));

  always_comb begin
    char_window_next       = char_window;
    enables_committed_next = enables_committed;
    enables_pending_next   = enables_pending;
    duty_committed_next    = duty_committed;
    duty_pending_next      = duty_pending;
    pwm_phase_next         = pwm_phase;
    pwm_brightness_next    = pwm_brightness;
    unique case (fn)
      FUNC_CHAR: begin
        if (delim && hit.led_hit) begin
          enables_pending_next[hit.led_idx] = hit.led_set;
        end
        if (delim && hit.pwm_hit) duty_pending_next = hit.pwm_duty;
        if (rx_char == CH_SEMI) begin
          enables_committed_next = enables_pending_next & LED_MASK;
          duty_committed_next    = duty_pending_next;
          char_window_next       = '0;
        end else begin
          char_window_next = {char_window[55:0], rx_char};
        end
      end
      FUNC_BRIGHTEN: begin
        duty_committed_next = (duty_committed >= PERIOD - DUTY_STEP) ?
                              PERIOD : duty_committed + DUTY_STEP;
        duty_pending_next   = duty_committed_next;
      end
      FUNC_DIM: begin
        duty_committed_next = (duty_committed >= DUTY_STEP) ?
                              duty_committed - DUTY_STEP : 7'd0;
        duty_pending_next   = duty_committed_next;
      end
      FUNC_TICK: begin
        if (pwm_phase == 7'd0) begin
          pwm_brightness_next = (bright_sum > PERIOD) ? PERIOD : bright_sum;
        end
        pwm_phase_next = (pwm_phase == PERIOD - 7'd1) ? 7'd0 : pwm_phase + 7'd1;
      end
      default: ;
    endcase
  end

  // tick shows the slot it drives, other words show the previous tick's slot
  always_comb begin
    if (fn == FUNC_TICK) slot_shown = pwm_phase;
    else if (pwm_phase == 7'd0) slot_shown = PERIOD - 7'd1;
    else slot_shown = pwm_phase - 7'd1;
  end

  always_comb begin
    item.echo_valid  = (fn == FUNC_CHAR);
    item.echo_char   = (fn == FUNC_CHAR) ? rx_char : 8'd0;
    item.led_enables = enables_committed_next;
    item.duty_level  = duty_committed_next;
    item.brightness  = pwm_brightness_next;
    item.led_on      = (slot_shown < pwm_brightness_next) ?
                       (enables_committed_next & LED_MASK) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_window       <= '0;
      enables_committed <= LED_MASK;
      enables_pending   <= LED_MASK;
      duty_committed    <= 7'd0;
      duty_pending      <= 7'd0;
      pwm_phase         <= 7'd0;
      pwm_brightness    <= 7'd0;
    end else if (in_fire) begin
      char_window       <= char_window_next;
      enables_committed <= enables_committed_next;
      enables_pending   <= enables_pending_next;
      duty_committed    <= duty_committed_next;
      duty_pending      <= duty_pending_next;
      pwm_phase         <= pwm_phase_next;
      pwm_brightness    <= pwm_brightness_next;
    end
  end

  ulcp_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (in_fire),
    .push_data (item),
    .full      (buf_full),
    .pop_valid (out_valid),
    .pop_ready (out_ready),
    .pop_data  (pop_item)
  );

  assign echo_valid  = pop_item.echo_valid;
  assign echo_char   = pop_item.echo_char;
  assign led_enables = pop_item.led_enables;
  assign duty_level  = pop_item.duty_level;
  assign brightness  = pop_item.brightness;
  assign led_on      = pop_item.led_on;

endmodule

FILE: tb/testbench.sv
// self-checking testbench for uart_led_command_pwm_controller_unit
// a directed table and random command, button and tick traffic, checked against a built-in model
// depends on ulcp_pkg (func_t, LED_W) and the controller rtl
module testbench;
  import ulcp_pkg::*;

  localparam int SLOTS    = 100;
  localparam int STEP     = 10;
  localparam int POT_STEP = 455;

  typedef struct packed {
    logic             echo_valid;
    logic [7:0]       echo_char;
    logic [LED_W-1:0] led_enables;
    logic [6:0]       duty_level;
    logic [6:0]       brightness;
    logic [LED_W-1:0] led_on;
  } led_word_t;

  typedef struct packed {
    func_t      f;
    logic [7:0] ch;
    logic [11:0] pot;
    logic       typed;
    led_word_t  want;
  } dir_row_t;

  localparam led_word_t NO_WANT = '0;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [1:0]       func = 2'd0;
  logic [7:0]       rx_char = 8'd0;
  logic [11:0]      pot_sample = 12'd0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic             echo_valid;
  logic [7:0]       echo_char;
  logic [LED_W-1:0] led_enables;
  logic [6:0]       duty_level;
  logic [6:0]       brightness;
  logic [LED_W-1:0] led_on;

  uart_led_command_pwm_controller_unit u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .func(func), .rx_char(rx_char), .pot_sample(pot_sample),
    .out_valid(out_valid), .out_ready(out_ready),
    .echo_valid(echo_valid), .echo_char(echo_char), .led_enables(led_enables),
    .duty_level(duty_level), .brightness(brightness), .led_on(led_on)
  );

  // model state
  logic [63:0]      win_q;
  logic [LED_W-1:0] en_live, en_next;
  logic [6:0]       duty_live, duty_next, slot_q, bright_q;

  led_word_t  led_words_due[$];
  dir_row_t   dir_tab [25];
  int         n_err = 0;
  int         n_sent = 0;
  bit         tx_quiet = 1'b0;
  bit         rx_quiet = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("[uart_led_command_pwm_controller_unit] ERROR");
    $finish;
  end

  // match the character window against the led and pwm commands
  function automatic void scan_window();
    logic [7:0] c [8];
    int nn;
    int v;
    for (int k = 0; k < 8; k++) c[k] = win_q[8*(7-k) +: 8];
    if (!(c[3] inside {["0":"9"]}) || !(c[4] inside {["0":"9"]}) || c[5] != "=") return;
    nn = (int'(c[3]) - 48) * 10 + (int'(c[4]) - 48);
    if (c[0] == "L" && c[1] == "E" && c[2] == "D") begin
      if (c[6] != "0" || nn < 4 || nn >= 4 + LED_COUNT) return;
      if (c[7] == "1") en_next[nn-4] = 1'b1;
      else if (c[7] == "0") en_next[nn-4] = 1'b0;
      return;
    end
    if (c[0] == "P" && c[1] == "W" && c[2] == "M" && nn == 1 &&
        c[6] inside {["0":"9"]} && c[7] inside {["0":"9"]}) begin
      v = (int'(c[6]) - 48) * 10 + (int'(c[7]) - 48);
      if (v <= 10) duty_next = 7'(v * STEP);
    end
  endfunction

  function automatic led_word_t predict_led_word(func_t f, logic [7:0] ch, logic [11:0] pot);
    led_word_t r;
    int lit_slot;
    int sum;
    r = '0;
    case (f)
      FUNC_CHAR: begin
        r.echo_valid = 1'b1;
        r.echo_char = ch;
        if (ch == "," || ch == ";") scan_window();
        if (ch == ";") begin
          en_live = en_next & LED_MASK;
          duty_live = duty_next;
          win_q = '0;
        end else begin
          win_q = {win_q[55:0], ch};
        end
      end
      FUNC_BRIGHTEN: begin
        duty_live = (int'(duty_live) + STEP >= SLOTS) ? 7'(SLOTS) : duty_live + 7'(STEP);
        duty_next = duty_live;
      end
      FUNC_DIM: begin
        duty_live = (int'(duty_live) >= STEP) ? duty_live - 7'(STEP) : 7'd0;
        duty_next = duty_live;
      end
      default: ;
    endcase
    if (f == FUNC_TICK) begin
      if (slot_q == 0) begin
        sum = int'(duty_live) + int'(pot) / POT_STEP;
        bright_q = (sum > SLOTS) ? 7'(SLOTS) : 7'(sum);
      end
      lit_slot = slot_q;
      slot_q = (int'(slot_q) + 1 >= SLOTS) ? 7'd0 : slot_q + 7'd1;
    end else begin
      // non-tick words show the slot of the previous tick
      lit_slot = (slot_q == 0) ? SLOTS - 1 : int'(slot_q) - 1;
    end
    r.led_enables = en_live;
    r.duty_level = duty_live;
    r.brightness = bright_q;
    r.led_on = (lit_slot < int'(bright_q)) ? en_live : '0;
    return r;
  endfunction

  task automatic send_word(func_t f, logic [7:0] ch, logic [11:0] pot, logic typed,
                           led_word_t want);
    int gap;
    led_word_t pred;
    gap = tx_quiet ? 0 : $urandom_range(0, 18);
    if ($urandom_range(0, 24) == 0) tx_quiet = !tx_quiet;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    rx_char <= ch;
    pot_sample <= pot;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = predict_led_word(f, ch, pot);
    led_words_due.push_back(typed ? want : pred);
    n_sent++;
  endtask

  task automatic send_text(logic [7:0] seq[$]);
    foreach (seq[i]) send_word(FUNC_CHAR, seq[i], 12'(i * 37), 1'b0, NO_WANT);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (led_words_due.size() != 0);
  endtask

  function automatic logic [7:0] digit_ch(int d);
    return 8'(48 + d);
  endfunction

  // random stimulus: commands with random content, mixed with junk text, buttons and ticks
  task automatic send_random();
    logic [7:0] seq[$];
    int kind;
    int nn;
    int r;
    int k;
    logic [11:0] pot;
    kind = $urandom_range(0, 99);
    if (kind < 55) begin
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 3)) seq.push_back(8'($urandom_range(0, 255)));
      end
      if (kind < 35) begin
        seq.push_back("L"); seq.push_back("E"); seq.push_back("D");
        nn = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 99) : $urandom_range(4, 15);
        seq.push_back(digit_ch(nn / 10)); seq.push_back(digit_ch(nn % 10));
        seq.push_back("=");
        seq.push_back(($urandom_range(0, 9) == 0) ? digit_ch($urandom_range(0, 9)) : 8'("0"));
        r = $urandom_range(0, 9);
        seq.push_back(r < 4 ? 8'("1") : r < 8 ? 8'("0") : 8'($urandom_range(0, 255)));
      end else begin
        seq.push_back("P"); seq.push_back("W"); seq.push_back("M");
        nn = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : 1;
        seq.push_back(digit_ch(nn / 10)); seq.push_back(digit_ch(nn % 10));
        seq.push_back("=");
        nn = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 10);
        seq.push_back(digit_ch(nn / 10)); seq.push_back(digit_ch(nn % 10));
      end
      // broken commands: one corrupted character or a truncated start
      if ($urandom_range(0, 9) == 0) seq[$urandom_range(0, seq.size() - 1)] =
          8'($urandom_range(0, 255));
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 3)) void'(seq.pop_front());
      seq.push_back($urandom_range(0, 1) ? 8'(",") : 8'(";"));
      send_text(seq);
    end else if (kind < 65) begin
      repeat ($urandom_range(1, 6)) begin
        r = $urandom_range(0, 9);
        seq.push_back(r == 0 ? 8'(",") : r == 1 ? 8'(";") : 8'($urandom_range(0, 255)));
      end
      send_text(seq);
    end else if (kind < 75) begin
      repeat ($urandom_range(1, 4))
        send_word(func_t'($urandom_range(1, 2)), 8'($urandom_range(0, 255)),
                  12'($urandom_range(0, 4095)), 1'b0, NO_WANT);
    end else begin
      repeat ($urandom_range(1, 40)) begin
        r = $urandom_range(0, 9);
        k = $urandom_range(1, 9);
        if (r == 0) pot = 12'd0;
        else if (r == 1) pot = 12'hfff;
        else if (r == 2) pot = 12'(k * POT_STEP - $urandom_range(0, 1));
        else pot = 12'($urandom_range(0, 4095));
        send_word(FUNC_TICK, 8'($urandom_range(0, 255)), pot, 1'b0, NO_WANT);
      end
    end
  endtask

  initial begin
    bit mid_pause_done;
    mid_pause_done = 1'b0;
    win_q = '0;
    en_live = LED_MASK;
    en_next = LED_MASK;
    duty_live = '0;
    duty_next = '0;
    slot_q = '0;
    bright_q = '0;
    dir_tab = '{
      '{FUNC_DIM,      8'h00, 12'h000, 1'b1, '{1'b0, 8'h00, 12'hfff, 7'd0,  7'd0,  12'h000}},
      '{FUNC_BRIGHTEN, 8'h00, 12'h000, 1'b1, '{1'b0, 8'h00, 12'hfff, 7'd10, 7'd0,  12'h000}},
      '{FUNC_TICK,     8'h00, 12'hfff, 1'b1, '{1'b0, 8'h00, 12'hfff, 7'd10, 7'd19, 12'hfff}},
      '{FUNC_CHAR,     "L",   12'h000, 1'b0, NO_WANT},
      '{FUNC_CHAR,     "E",   12'h000, 1'b0, NO_WANT},
      '{FUNC_CHAR,     "D",   12'h000, 1'b0, NO_WANT},
      '{FUNC_CHAR,     "1",   12'h000, 1'b0, NO_WANT},
      '{FUNC_CHAR,     "5",   12'h000, 1'b0, NO_WANT},
      '{FUNC_CHAR,     "=",   12'h000, 1'b0, NO_WANT},
      '{FUNC_CHAR,     "0",   12'h000, 1'b0, NO_WANT},
      '{FUNC_CHAR,     "0",   12'h000, 1'b0, NO_WANT},
      '{FUNC_CHAR,     ",",   12'h000, 1'b0, NO_WANT},
      '{FUNC_CHAR,     ";",   12'h000, 1'b0, NO_WANT},
      '{FUNC_CHAR,     "P",   12'h000, 1'b0, NO_WANT},
      '{FUNC_CHAR,     "W",   12'h000, 1'b0, NO_WANT},
      '{FUNC_CHAR,     "M",   12'h000, 1'b0, NO_WANT},
      '{FUNC_CHAR,     "0",   12'h000, 1'b0, NO_WANT},
      '{FUNC_CHAR,     "1",   12'h000, 1'b0, NO_WANT},
      '{FUNC_CHAR,     "=",   12'h000, 1'b0, NO_WANT},
      '{FUNC_CHAR,     "1",   12'h000, 1'b0, NO_WANT},
      '{FUNC_CHAR,     "0",   12'h000, 1'b0, NO_WANT},
      '{FUNC_CHAR,     ";",   12'h000, 1'b0, NO_WANT},
      '{FUNC_BRIGHTEN, 8'h00, 12'h000, 1'b0, NO_WANT},
      '{FUNC_CHAR,     8'hff, 12'h000, 1'b0, NO_WANT},
      '{FUNC_TICK,     8'h00, 12'h000, 1'b0, NO_WANT}
    };
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    foreach (dir_tab[i])
      send_word(dir_tab[i].f, dir_tab[i].ch, dir_tab[i].pot, dir_tab[i].typed, dir_tab[i].want);
    wait_drained();
    while (n_sent < 25 + 850) begin
      if (!mid_pause_done && n_sent >= 450) begin
        wait_drained();
        mid_pause_done = 1'b1;
      end
      send_random();
    end
    wait_drained();
    repeat (10) @(posedge clk);
    if (n_err == 0) $display("[uart_led_command_pwm_controller_unit] OK");
    else $display("[uart_led_command_pwm_controller_unit] ERROR");
    $finish;
  end

  // result side: random stalls plus two long hold-offs that back up the block
  initial begin
    int gap;
    int n_got;
    n_got = 0;
    while (rst) @(posedge clk);
    forever begin
      if (n_got == 150 || n_got == 500) gap = 80;
      else gap = rx_quiet ? 0 : $urandom_range(0, 18);
      if ($urandom_range(0, 24) == 0) rx_quiet = !rx_quiet;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      n_got++;
    end
  end

  task automatic check_field(string what, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, what, want, got);
      n_err++;
    end
  endtask

  always @(posedge clk) begin : result_check
    led_word_t w;
    if (!rst && out_valid && out_ready) begin
      if (led_words_due.size() == 0) begin
        $display("%0t: result word with nothing expected", $realtime);
        n_err++;
      end else begin
        w = led_words_due.pop_front();
        check_field("echo_valid", w.echo_valid, echo_valid);
        check_field("echo_char", w.echo_char, echo_char);
        check_field("led_enables", w.led_enables, led_enables);
        check_field("duty_level", w.duty_level, duty_level);
        check_field("brightness", w.brightness, brightness);
        check_field("led_on", w.led_on, led_on);
      end
    end
  end

endmodule
